### src/psgh_pkg.sv
// ----------------------------------------------------------------------------
// psgh_pkg
// constants and helpers for the path string guid hash core
// ----------------------------------------------------------------------------
package psgh_pkg;

    typedef logic [31:0] t_word;
    typedef logic [63:0] t_dword;

    localparam t_word FOLD_KEY    = 32'h5C5C_5C5C;
    localparam t_word BYTE_ONES   = 32'h0101_0101;
    localparam t_word CASE_MASK   = 32'hDFDF_DFDF;
    localparam t_word BYTE_HIGHS  = 32'h8080_8080;
    localparam t_word SLASH_DELTA = 32'd45;

    // word multiplier 0xFB8C4D96501 split into 32-bit and 12-bit halves
    localparam logic [31:0] MUL_WORD_LO = 32'hC4D9_6501;
    localparam logic [11:0] MUL_WORD_HI = 12'hFB8;
    // accumulator multiplier
    localparam logic [26:0] MUL_ACC     = 27'h633_D5F1;
    // length multiplier 0xAE502812AA7333 split into 32-bit and 24-bit halves
    localparam logic [31:0] MUL_LEN_LO  = 32'h12AA_7333;
    localparam logic [23:0] MUL_LEN_HI  = 24'hAE_5028;

    localparam t_word LEN_STEP = 32'd4;

    // per-beat decode of one text word
    typedef struct packed {
        logic       term;  // word holds the terminator
        logic [1:0] idx;   // byte position of the terminator
        t_word      fold;  // folded word, masked below terminator when term
    } t_word_info;

    function automatic t_word_info decode_word(input t_word w);
        t_word      x;
        t_word      m;
        t_word      f;
        t_word      z;
        t_word      lowest;
        t_word_info info;
        x      = w ^ FOLD_KEY;
        m      = (~x >> 7) & ((x - BYTE_ONES) >> 7) & BYTE_ONES;
        f      = (w - SLASH_DELTA * m) & CASE_MASK;
        z      = ~w & (w - BYTE_ONES) & BYTE_HIGHS;
        lowest = z & (32'd0 - z);
        info.term = (z != 32'd0);
        if (lowest[7]) begin
            info.idx = 2'd0;
        end else if (lowest[15]) begin
            info.idx = 2'd1;
        end else if (lowest[23]) begin
            info.idx = 2'd2;
        end else begin
            info.idx = 2'd3;
        end
        info.fold = info.term ? (f & (lowest - 32'd1)) : f;
        return info;
    endfunction

endpackage

### src/path_string_guid_hash_core.sv
// ----------------------------------------------------------------------------
// path_string_guid_hash_core
// streaming 64-bit guid hash of a zero-terminated path, four bytes a beat
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  text    | in        | i_valid / o_stall     | i_text_word[31:0]
//  guid    | out       | o_valid / i_stall     | o_guid[63:0], o_string_length
//
//  one text beat a cycle while nothing stalls; a guid beat leaves after the
//  beat holding the terminator has passed the input reg, fold/multiply,
//  word term, accumulator update, length products and output reg stages
//  the loop that sets the rate is the accumulator update: two 32x27
//  constant products, a three-input 64-bit add, fold-back xor, once a cycle
//  i_rst_n is synchronous, active low; clears valids, accumulator and count
//  i_stall holds the output; stages behind it keep filling their bubbles
//  and o_stall rises only once the input stage cannot move
// ----------------------------------------------------------------------------
module path_string_guid_hash_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  psgh_pkg::t_word      i_text_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output psgh_pkg::t_dword     o_guid,
    output psgh_pkg::t_word      o_string_length
);
    import psgh_pkg::*;

    // stage 0: input register
    logic        r_s0_vld;
    t_word       r_s0_word;
    // stage 1: decoded word and the two partial products of the word term
    logic        r_s1_vld;
    logic        r_s1_term;
    logic [1:0]  r_s1_idx;
    logic [63:0] r_s1_plo;
    logic [43:0] r_s1_phi;
    // stage 2: word term ready for the accumulator
    logic        r_s2_vld;
    logic        r_s2_term;
    logic [1:0]  r_s2_idx;
    logic [39:0] r_s2_t;
    // running state
    t_dword      r_acc;
    t_word       r_cnt;
    // stage 3: finished sum and length of one string
    logic        r_s3_vld;
    t_dword      r_s3_u;
    t_word       r_s3_len;
    // stage 4: length correction partial products
    logic        r_s4_vld;
    t_dword      r_s4_u;
    t_word       r_s4_len;
    logic [63:0] r_s4_qlo;
    t_word       r_s4_qhi;
    // output register
    logic        r_o_vld;
    t_dword      r_o_guid;
    t_word       r_o_len;

    // each stage takes a beat when empty or when it passes its own beat on
    logic acc_o, acc_4, acc_3, acc_2, acc_1, acc_0;

    assign acc_o = !r_o_vld || !i_stall;
    assign acc_4 = !r_s4_vld || acc_o;
    assign acc_3 = !r_s3_vld || acc_4;
    // a word without terminator leaves stage 2 into the accumulator only
    assign acc_2 = !r_s2_vld || !r_s2_term || acc_3;
    assign acc_1 = !r_s1_vld || acc_2;
    assign acc_0 = !r_s0_vld || acc_1;

    assign o_stall = !acc_0;

    // fold and terminator search on the registered word
    t_word_info s0_info;
    assign s0_info = decode_word(r_s0_word);

    // word term (MUL_WORD * f mod 2^64) >> 24
    t_dword s1_sum;
    assign s1_sum = r_s1_plo + {r_s1_phi[31:0], 32'd0};

    // accumulator times MUL_ACC, mod 2^64, as two 32x27 products
    logic [58:0] acc_plo;
    logic [58:0] acc_phi;
    t_dword      u;
    assign acc_plo = 59'(r_acc[31:0]) * 59'(MUL_ACC);
    assign acc_phi = 59'(r_acc[63:32]) * 59'(MUL_ACC);
    assign u       = {5'd0, acc_plo} + {acc_phi[31:0], 32'd0} + {24'd0, r_s2_t};

    logic s2_fire;
    assign s2_fire = r_s2_vld && acc_2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_o_vld  <= 1'b0;
            r_acc    <= '0;
            r_cnt    <= '0;
        end else begin
            if (acc_0) begin
                r_s0_vld <= i_valid;
            end
            if (acc_1) begin
                r_s1_vld <= r_s0_vld;
            end
            if (acc_2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (acc_3) begin
                r_s3_vld <= s2_fire && r_s2_term;
            end
            if (acc_4) begin
                r_s4_vld <= r_s3_vld;
            end
            if (acc_o) begin
                r_o_vld <= r_s4_vld;
            end
            // accumulator update, or clear once a string ends
            if (s2_fire) begin
                if (r_s2_term) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else begin
                    r_acc <= u ^ (u >> 61);
                    r_cnt <= r_cnt + LEN_STEP;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (acc_0) begin
            r_s0_word <= i_text_word;
        end
        if (acc_1) begin
            r_s1_term <= s0_info.term;
            r_s1_idx  <= s0_info.idx;
            r_s1_plo  <= 64'(s0_info.fold) * 64'(MUL_WORD_LO);
            r_s1_phi  <= 44'(s0_info.fold) * 44'(MUL_WORD_HI);
        end
        if (acc_2) begin
            r_s2_term <= r_s1_term;
            r_s2_idx  <= r_s1_idx;
            r_s2_t    <= s1_sum[63:24];
        end
        if (acc_3) begin
            r_s3_u   <= u;
            r_s3_len <= r_cnt + {30'd0, r_s2_idx};
        end
        if (acc_4) begin
            r_s4_u   <= r_s3_u;
            r_s4_len <= r_s3_len;
            r_s4_qlo <= 64'(r_s3_len) * 64'(MUL_LEN_LO);
            r_s4_qhi <= r_s3_len * 32'(MUL_LEN_HI);
        end
        if (acc_o) begin
            // length correction, mod 2^64
            r_o_guid <= r_s4_u - r_s4_qlo - {r_s4_qhi, 32'd0};
            r_o_len  <= r_s4_len;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_guid          = r_o_guid;
    assign o_string_length = r_o_len;

endmodule
